// File: rtl/als_pkg.sv
// Package for the audio level statistics block: widths, register indexes,
// and the snapshot handed from the accumulator to the finisher.
// No dependencies.
package als_pkg;

   localparam int MaxFrames   = 2097152;
   localparam int CountW      = 22;
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 16;

   localparam logic [CsrIdxW-1:0] RegMonoSource = 3'd0;
   localparam logic [CsrIdxW-1:0] RegClipThresh = 3'd1;
   localparam logic [CsrIdxW-1:0] RegSilThresh  = 3'd2;
   localparam logic [CsrIdxW-1:0] RegLowSmooth  = 3'd3;
   localparam logic [CsrIdxW-1:0] RegHighSmooth = 3'd4;

   // Totals of one clip, captured on the last frame.
   typedef struct packed {
      logic [21:0] frames;
      logic [51:0] square_sum;
      logic [36:0] absolute_sum;
      logic [15:0] peak;
      logic [21:0] clip_tally;
      logic [21:0] quiet_tally;
      logic [20:0] crossing_tally;
      logic [36:0] rise_sum;
      logic [53:0] band0;
      logic [53:0] band1;
      logic [53:0] band2;
   } snap_type;

endpackage

// File: rtl/als_accum.sv
// Front part: takes frames, mixes to mono and updates running sums.
// Depends on als_pkg.
module als_accum import als_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [15:0] req_left_sample,
   input  logic signed [15:0] req_right_sample,
   input  logic              req_last_frame,
   input  logic              mono_source,
   input  logic [15:0]       clip_threshold,
   input  logic [15:0]       silence_threshold,
   input  logic [15:0]       low_smoothing,
   input  logic [15:0]       high_smoothing,
   output logic              snap_valid,
   input  logic              snap_ready,
   output snap_type          snap
);

   // stage 1 registers (mono sample, valid)
   logic               s1_valid_ff;
   logic               s1_last_ff;
   logic signed [15:0] s1_mono_ff;
   // stage 2 registers: delayed mono sample and flags for the band energies
   logic               s2_valid_ff;
   logic               s2_last_ff;
   logic               s2_acc_ff;
   logic signed [15:0] s2_mono_ff;

   logic [51:0] sq_ff;
   logic [36:0] abs_ff, rise_ff;
   logic [15:0] peak_ff, last_mag_ff;
   logic [21:0] clip_ff, quiet_ff, frames_ff;
   logic [20:0] cross_ff;
   logic        prev_neg_ff;
   logic signed [24:0] slow_ff, fast_ff;
   logic [53:0] band0_ff, band1_ff, band2_ff;
   logic        snap_valid_ff;
   snap_type    snap_ff;

   logic signed [16:0] sum_lr;
   logic signed [15:0] mono_in;
   logic        accept;
   logic        busy;

   // hold intake while a clip total waits or the pipe carries a last frame
   assign busy      = snap_valid_ff || (s1_valid_ff && s1_last_ff) ||
                      (s2_valid_ff && s2_last_ff);
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   assign sum_lr  = 17'(req_left_sample) + 17'(req_right_sample);
   assign mono_in = mono_source ? req_left_sample : sum_lr[16:1];

   // per-frame arithmetic on the stage 1 sample
   logic [15:0]        a;
   logic signed [24:0] x;
   logic signed [42:0] slow_p, fast_p;
   logic signed [24:0] slow_nx, fast_nx;
   logic signed [25:0] d_slow, d_fast;
   logic signed [17:0] b0, b1, b2;
   logic               acc_ok;
   logic               first;

   assign a      = s1_mono_ff[15] ? 16'(-s1_mono_ff) : 16'(s1_mono_ff);
   assign x      = 25'(s1_mono_ff) <<< 8;
   assign d_slow = 26'(x) - 26'(slow_ff);
   assign d_fast = 26'(x) - 26'(fast_ff);
   assign slow_p = 43'($signed({1'b0, low_smoothing}) * d_slow) + 43'sd32768;
   assign fast_p = 43'($signed({1'b0, high_smoothing}) * d_fast) + 43'sd32768;
   assign slow_nx = slow_ff + 25'(slow_p >>> 16);
   assign fast_nx = fast_ff + 25'(fast_p >>> 16);
   assign acc_ok  = frames_ff < 22'(MaxFrames);
   assign first   = frames_ff == '0;

   logic signed [26:0] bb0, bb1, bb2;
   assign bb0 = 27'(slow_ff) + 27'sd128;
   assign bb1 = 27'(fast_ff) - 27'(slow_ff) + 27'sd128;
   assign bb2 = (27'(s2_mono_ff) <<< 8) - 27'(fast_ff) + 27'sd128;
   assign b0  = 18'(bb0 >>> 8);
   assign b1  = 18'(bb1 >>> 8);
   assign b2  = 18'(bb2 >>> 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         frames_ff <= '0; sq_ff <= '0; abs_ff <= '0; rise_ff <= '0;
         peak_ff <= '0; last_mag_ff <= '0; clip_ff <= '0; quiet_ff <= '0;
         cross_ff <= '0; prev_neg_ff <= 1'b0; slow_ff <= '0; fast_ff <= '0;
         band0_ff <= '0; band1_ff <= '0; band2_ff <= '0;
         s1_last_ff <= 1'b0; s2_last_ff <= 1'b0; s2_acc_ff <= 1'b0;
      end else begin
         // advance stages 1 and 2
         s1_valid_ff <= accept;
         s1_last_ff  <= accept && req_last_frame;
         if (accept) s1_mono_ff <= mono_in;
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_valid_ff && s1_last_ff;
         s2_acc_ff   <= s1_valid_ff && acc_ok;
         s2_mono_ff  <= s1_mono_ff;
         // scalar sums and smoothers
         if (s1_valid_ff && acc_ok) begin
            sq_ff  <= sq_ff + 52'(32'(s1_mono_ff * s1_mono_ff));
            abs_ff <= abs_ff + 37'(a);
            if (a > peak_ff) peak_ff <= a;
            if (a >= clip_threshold) clip_ff <= clip_ff + 22'd1;
            if (a < silence_threshold) quiet_ff <= quiet_ff + 22'd1;
            if (!first) begin
               if (s1_mono_ff[15] != prev_neg_ff) cross_ff <= cross_ff + 21'd1;
               if (a > last_mag_ff) rise_ff <= rise_ff + 37'(a - last_mag_ff);
            end
            prev_neg_ff <= s1_mono_ff[15];
            last_mag_ff <= a;
            slow_ff     <= slow_nx;
            fast_ff     <= fast_nx;
            frames_ff   <= frames_ff + 22'd1;
         end
         // band energies use the smoothers in the cycle after they take the frame
         if (s2_acc_ff && !s2_last_ff) begin
            band0_ff <= band0_ff + 54'(36'(b0 * b0));
            band1_ff <= band1_ff + 54'(36'(b1 * b1));
            band2_ff <= band2_ff + 54'(36'(b2 * b2));
         end
         // hand off totals and clear on the last frame
         if (snap_valid_ff && snap_ready) snap_valid_ff <= 1'b0;
         if (s2_valid_ff && s2_last_ff) begin
            snap_valid_ff          <= 1'b1;
            snap_ff.frames         <= frames_ff;
            snap_ff.square_sum     <= sq_ff;
            snap_ff.absolute_sum   <= abs_ff;
            snap_ff.peak           <= peak_ff;
            snap_ff.clip_tally     <= clip_ff;
            snap_ff.quiet_tally    <= quiet_ff;
            snap_ff.crossing_tally <= cross_ff;
            snap_ff.rise_sum       <= rise_ff;
            snap_ff.band0 <= s2_acc_ff ? band0_ff + 54'(36'(b0 * b0)) : band0_ff;
            snap_ff.band1 <= s2_acc_ff ? band1_ff + 54'(36'(b1 * b1)) : band1_ff;
            snap_ff.band2 <= s2_acc_ff ? band2_ff + 54'(36'(b2 * b2)) : band2_ff;
            frames_ff <= '0; sq_ff <= '0; abs_ff <= '0; rise_ff <= '0;
            peak_ff <= '0; last_mag_ff <= '0; clip_ff <= '0; quiet_ff <= '0;
            cross_ff <= '0; prev_neg_ff <= 1'b0; slow_ff <= '0; fast_ff <= '0;
            band0_ff <= '0; band1_ff <= '0; band2_ff <= '0;
         end
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// File: rtl/als_finish.sv
// Back part: divides the clip totals by the frame count, takes square roots
// and forms the crest factor, one bit a cycle. Depends on als_pkg.
module als_finish import als_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        snap_valid,
   output logic        snap_ready,
   input  snap_type    snap,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [21:0] rsp_frame_total,
   output logic [15:0] rsp_rms_level,
   output logic [15:0] rsp_mean_absolute,
   output logic [15:0] rsp_peak_level,
   output logic [21:0] rsp_clipping_count,
   output logic [21:0] rsp_silence_count,
   output logic [20:0] rsp_crossing_count,
   output logic [15:0] rsp_crest_ratio,
   output logic [15:0] rsp_flux_mean,
   output logic [15:0] rsp_low_band_rms,
   output logic [15:0] rsp_mid_band_rms,
   output logic [15:0] rsp_high_band_rms
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SQRT, ST_CREST, ST_OUT
   } state_type;

   state_type state_ff;
   snap_type  s_ff;
   logic [2:0]  job_ff;     // 0 square,1 abs,2 rise,3..5 bands
   logic [5:0]  step_ff;
   logic [54:0] num_ff;     // dividend shifted out
   logic [54:0] quo_ff;
   logic [21:0] rem_ff;
   logic [55:0] sx_ff;      // root operand
   logic [27:0] root_ff;
   logic [55:0] srem_ff;
   logic [24:0] cnum_ff;
   logic [24:0] crem_ff;
   logic [24:0] cquo_ff;
   logic [15:0] rms_ff, mabs_ff, flux_ff, lo_ff, mid_ff, hi_ff, crest_ff;

   logic [22:0] rem_sh;
   logic [57:0] trial;
   logic [57:0] srem_sh;
   logic [25:0] crem_sh;
   logic [15:0] clamp;

   // dividend with half the divisor added, for round half up
   function automatic logic [54:0] pick_next(input logic [2:0] j);
      logic [54:0] v;
      case (j)
         3'd0:    v = 55'(s_ff.square_sum);
         3'd1:    v = 55'(s_ff.absolute_sum);
         3'd2:    v = 55'(s_ff.rise_sum);
         3'd3:    v = 55'(s_ff.band0);
         3'd4:    v = 55'(s_ff.band1);
         default: v = 55'(s_ff.band2);
      endcase
      return v + 55'(s_ff.frames[21:1]);
   endfunction

   assign rem_sh  = {rem_ff, num_ff[54]};
   assign srem_sh = {srem_ff, sx_ff[55:54]};
   assign trial   = {28'd0, root_ff, 2'b01};
   assign crem_sh = {crem_ff, cnum_ff[24]};
   assign clamp   = |root_ff[27:16] ? 16'hFFFF : root_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (snap_valid) begin
                  s_ff     <= snap;
                  job_ff   <= 3'd0;
                  state_ff <= ST_DIV;
                  step_ff  <= '0;
                  rem_ff   <= '0;
                  num_ff   <= 55'(snap.square_sum) + 55'(snap.frames[21:1]);
               end
            end
            // restoring divide, one quotient bit a cycle
            ST_DIV: begin
               num_ff <= num_ff << 1;
               if (rem_sh >= {1'b0, s_ff.frames}) begin
                  rem_ff <= 22'(rem_sh - {1'b0, s_ff.frames});
                  quo_ff <= {quo_ff[53:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[21:0];
                  quo_ff <= {quo_ff[53:0], 1'b0};
               end
               if (step_ff == 6'd54) begin
                  state_ff <= ST_SQRT;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            ST_SQRT: begin
               if (step_ff == 6'd0 && (job_ff == 3'd1 || job_ff == 3'd2)) begin
                  if (job_ff == 3'd1) mabs_ff <= quo_ff[15:0];
                  else                flux_ff <= quo_ff[15:0];
                  step_ff <= 6'd29;
               end else if (step_ff == 6'd0) begin
                  sx_ff   <= {1'b0, quo_ff};
                  root_ff <= '0;
                  srem_ff <= '0;
                  step_ff <= 6'd1;
               end else if (step_ff <= 6'd28) begin
                  // one root bit a cycle
                  sx_ff <= sx_ff << 2;
                  if (srem_sh >= trial) begin
                     srem_ff <= 56'(srem_sh - trial);
                     root_ff <= {root_ff[26:0], 1'b1};
                  end else begin
                     srem_ff <= srem_sh[55:0];
                     root_ff <= {root_ff[26:0], 1'b0};
                  end
                  step_ff <= step_ff + 6'd1;
               end else begin
                  case (job_ff)
                     3'd0:    rms_ff <= root_ff[15:0];
                     3'd3:    lo_ff  <= clamp;
                     3'd4:    mid_ff <= clamp;
                     3'd5:    hi_ff  <= clamp;
                     default: ;
                  endcase
                  if (job_ff == 3'd5) begin
                     state_ff <= ST_CREST;
                     step_ff  <= '0;
                     cnum_ff  <= 25'({s_ff.peak, 8'd0}) + 25'(rms_ff[15:1]);
                     crem_ff  <= '0;
                  end else begin
                     job_ff   <= job_ff + 3'd1;
                     state_ff <= ST_DIV;
                     step_ff  <= '0;
                     rem_ff   <= '0;
                     num_ff   <= pick_next(job_ff + 3'd1);
                  end
               end
            end
            // crest: peak*256 over rms
            ST_CREST: begin
               cnum_ff <= cnum_ff << 1;
               if (crem_sh >= {10'd0, rms_ff}) begin
                  crem_ff <= 25'(crem_sh - {10'd0, rms_ff});
                  cquo_ff <= {cquo_ff[23:0], 1'b1};
               end else begin
                  crem_ff <= crem_sh[24:0];
                  cquo_ff <= {cquo_ff[23:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd25) begin
                  if (rms_ff == '0)        crest_ff <= '0;
                  else if (|cquo_ff[24:16]) crest_ff <= 16'hFFFF;
                  else                     crest_ff <= cquo_ff[15:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign snap_ready         = state_ff == ST_IDLE;
   assign rsp_valid          = state_ff == ST_OUT;
   assign rsp_frame_total    = s_ff.frames;
   assign rsp_rms_level      = rms_ff;
   assign rsp_mean_absolute  = mabs_ff;
   assign rsp_peak_level     = s_ff.peak;
   assign rsp_clipping_count = s_ff.clip_tally;
   assign rsp_silence_count  = s_ff.quiet_tally;
   assign rsp_crossing_count = s_ff.crossing_tally;
   assign rsp_crest_ratio    = crest_ff;
   assign rsp_flux_mean      = flux_ff;
   assign rsp_low_band_rms   = lo_ff;
   assign rsp_mid_band_rms   = mid_ff;
   assign rsp_high_band_rms  = hi_ff;

endmodule

// File: rtl/audio_level_statistics.sv
// Audio level statistics top level: register file, accumulator, finisher.
// One frame a cycle unless stalled; scalar sums take each frame from the
// stage 1 registers, band sums from the stage 2 registers. A last frame
// stalls intake, as does a full snapshot, until the finisher takes it. The
// result follows six divides, four square roots and the crest divide.
// Reset is synchronous: sums, handshakes and registers return to defaults.
module audio_level_statistics import als_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_left_sample,
   input  logic signed [15:0] req_right_sample,
   input  logic        req_last_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [21:0] rsp_frame_total,
   output logic [15:0] rsp_rms_level,
   output logic [15:0] rsp_mean_absolute,
   output logic [15:0] rsp_peak_level,
   output logic [21:0] rsp_clipping_count,
   output logic [21:0] rsp_silence_count,
   output logic [20:0] rsp_crossing_count,
   output logic [15:0] rsp_crest_ratio,
   output logic [15:0] rsp_flux_mean,
   output logic [15:0] rsp_low_band_rms,
   output logic [15:0] rsp_mid_band_rms,
   output logic [15:0] rsp_high_band_rms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   logic        mono_ff;
   logic [15:0] clip_ff, sil_ff, low_ff, high_ff;
   logic        snap_valid, snap_ready;
   snap_type    snap;

   assign csr_ready = 1'b1;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff <= 1'b0;
         clip_ff <= 16'd32735;
         sil_ff  <= 16'd33;
         low_ff  <= 16'd655;
         high_ff <= 16'd13107;
      end else if (csr_valid) begin
         case (csr_index)
            RegMonoSource: mono_ff <= csr_data[0];
            RegClipThresh: clip_ff <= csr_data;
            RegSilThresh:  sil_ff  <= csr_data;
            RegLowSmooth:  low_ff  <= csr_data;
            RegHighSmooth: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   als_accum u_accum (
      .clock, .reset, .req_valid, .req_stall, .req_left_sample,
      .req_right_sample, .req_last_frame,
      .mono_source(mono_ff), .clip_threshold(clip_ff),
      .silence_threshold(sil_ff), .low_smoothing(low_ff),
      .high_smoothing(high_ff),
      .snap_valid, .snap_ready, .snap
   );

   als_finish u_finish (
      .clock, .reset, .snap_valid, .snap_ready, .snap,
      .rsp_valid, .rsp_stall, .rsp_frame_total, .rsp_rms_level,
      .rsp_mean_absolute, .rsp_peak_level, .rsp_clipping_count,
      .rsp_silence_count, .rsp_crossing_count, .rsp_crest_ratio,
      .rsp_flux_mean, .rsp_low_band_rms, .rsp_mid_band_rms,
      .rsp_high_band_rms
   );

endmodule
